>>> hdl/bsf16_pkg.sv
// Shared types and constants for the bit-serial Fletcher-16 framer.
package bsf16_pkg;

   // One classified input item as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eom;
   } item_type;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [8:0] FL_MOD    = 9'd255;
   localparam logic [3:0] BYTE_LAST = 4'd7;
   localparam logic [3:0] TRL_LAST  = 4'd15;

endpackage

>>> hdl/bsf16_front.sv
// Input stage: register items, drop idle ones, hand the rest to the queue.
module bsf16_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_present,
   input  logic                req_end_of_message,
   output logic                push_valid,
   input  logic                push_ready,
   output bsf16_pkg::item_type push_item
);
   import bsf16_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_ready  = !vld_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = vld_ff;
   assign push_item  = item_ff;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (push_ready) begin
         vld_in = 1'b0;
      end
      if (accept) begin
         // drop items that carry neither a byte nor an end mark
         vld_in          = req_byte_present || req_end_of_message;
         item_in.data    = req_data_byte;
         item_in.present = req_byte_present;
         item_in.eom     = req_end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

endmodule

>>> hdl/bsf16_queue.sv
// Short FIFO of classified items between front and back.
module bsf16_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  bsf16_pkg::item_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output bsf16_pkg::item_type pop_item
);
   import bsf16_pkg::*;

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/bsf16_back.sv
// Serializer: shift out byte bits, fold them into the sums, append the trailer.
module bsf16_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  bsf16_pkg::item_type pop_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_out_bit,
   output logic                rsp_is_checksum_bit,
   output logic                rsp_last_in_run,
   output logic                rsp_end_of_frame
);
   import bsf16_pkg::*;

   localparam logic PH_BYTE = 1'b0;
   localparam logic PH_TRL  = 1'b1;

   logic        busy_ff, busy_in;
   logic        phase_ff, phase_in;
   logic        eom_ff, eom_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] sh_ff, sh_in;
   logic [7:0]  sf_ff, sf_in;
   logic [7:0]  ss_ff, ss_in;

   logic        vld_ff, vld_in;
   logic        bit_ff, bit_in;
   logic        chk_ff, chk_in;
   logic        last_ff, last_in;
   logic        eof_ff, eof_in;

   logic        adv, done, byte_last, trl_last, bit_w;
   logic [8:0]  f_add, s_add;
   logic [7:0]  f_upd, s_upd;

   assign rsp_valid           = vld_ff;
   assign rsp_out_bit         = bit_ff;
   assign rsp_is_checksum_bit = chk_ff;
   assign rsp_last_in_run     = last_ff;
   assign rsp_end_of_frame    = eof_ff;

   always_comb begin
      adv       = busy_ff && (!vld_ff || rsp_ready);
      bit_w     = sh_ff[15];
      byte_last = (phase_ff == PH_BYTE) && (cnt_ff == BYTE_LAST);
      trl_last  = (phase_ff == PH_TRL) && (cnt_ff == TRL_LAST);
      done      = (byte_last && !eom_ff) || trl_last;
      pop_ready = !busy_ff || (adv && done);

      // mod-255 updates: first sum never passes 255, second stays below 510
      f_add = {1'b0, sf_ff} + {8'd0, bit_w};
      f_upd = (f_add == FL_MOD) ? 8'd0 : f_add[7:0];
      s_add = {1'b0, ss_ff} + {1'b0, f_upd};
      s_upd = (s_add >= FL_MOD) ? 8'(s_add - FL_MOD) : s_add[7:0];

      busy_in  = busy_ff;
      phase_in = phase_ff;
      eom_in   = eom_ff;
      cnt_in   = cnt_ff;
      sh_in    = sh_ff;
      sf_in    = sf_ff;
      ss_in    = ss_ff;

      vld_in  = vld_ff && !rsp_ready;
      bit_in  = bit_ff;
      chk_in  = chk_ff;
      last_in = last_ff;
      eof_in  = eof_ff;

      if (adv) begin
         vld_in  = 1'b1;
         bit_in  = bit_w;
         chk_in  = (phase_ff == PH_TRL);
         last_in = done;
         eof_in  = trl_last;
         sh_in   = {sh_ff[14:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (phase_ff == PH_BYTE) begin
            sf_in = f_upd;
            ss_in = s_upd;
            if (byte_last) begin
               if (eom_ff) begin
                  phase_in = PH_TRL;
                  cnt_in   = 4'd0;
                  sh_in    = {f_upd, s_upd};
               end else begin
                  busy_in = 1'b0;
               end
            end
         end else if (trl_last) begin
            sf_in   = 8'd0;
            ss_in   = 8'd0;
            busy_in = 1'b0;
         end
      end

      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         eom_in  = pop_item.eom;
         cnt_in  = 4'd0;
         if (pop_item.present) begin
            phase_in = PH_BYTE;
            sh_in    = {pop_item.data, 8'd0};
         end else begin
            // empty end item: trailer straight from the settled sums
            phase_in = PH_TRL;
            sh_in    = {sf_in, ss_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
         sf_ff   <= 8'd0;
         ss_ff   <= 8'd0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
         sf_ff   <= sf_in;
         ss_ff   <= ss_in;
      end
      phase_ff <= phase_in;
      eom_ff   <= eom_in;
      cnt_ff   <= cnt_in;
      sh_ff    <= sh_in;
      bit_ff   <= bit_in;
      chk_ff   <= chk_in;
      last_ff  <= last_in;
      eof_ff   <= eof_in;
   end

endmodule

>>> hdl/bit_serial_fletcher16_framer_top.sv
// Top level of the bit-serial Fletcher-16 framer: front, item queue, serializer.
// Path: front register, queue memory, serializer shift register, then the registered rsp_ ports.
// Throughput: one bit per cycle from the serializer while rsp_ready is high; 8 bits
//   per byte item, 16 per empty end item, 24 per byte with end mark; idle items are dropped at the front.
// Reset: synchronous, active high; empties the queue and output, clears both sums.
module bit_serial_fletcher16_framer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_bit,
   output logic       rsp_is_checksum_bit,
   output logic       rsp_last_in_run,
   output logic       rsp_end_of_frame
);
   import bsf16_pkg::*;

   // front -> queue
   logic     push_valid, push_ready;
   item_type push_item;
   // queue -> serializer
   logic     pop_valid, pop_ready;
   item_type pop_item;

   // Register each item, drop idle ones, forward the rest.
   bsf16_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_item          (push_item)
   );

   // Buffer items so the front keeps accepting while a byte is being shifted out.
   bsf16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Shift bits out MSB first, advance the sums, append the 16-bit trailer.
   // The next item is taken in the cycle the current one emits its last bit.
   bsf16_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_item            (pop_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_bit         (rsp_out_bit),
      .rsp_is_checksum_bit (rsp_is_checksum_bit),
      .rsp_last_in_run     (rsp_last_in_run),
      .rsp_end_of_frame    (rsp_end_of_frame)
   );

endmodule
